@@ rtl/core/lsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lsc_pkg;

	localparam int unsigned AngleW = 16;
	localparam int unsigned StepW  = 32;
	localparam int unsigned RangeW = 16;
	localparam int unsigned AgeW   = 16;
	localparam int unsigned SpeedW = 7;
	localparam int unsigned DriveW = 8;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [SpeedW-1:0] SpeedCap = SpeedW'(100);
	localparam logic [AgeW-1:0]   AgeMax   = {AgeW{1'b1}};

	// register indexes
	localparam logic [CfgIdxW-1:0] RegMinAngle  = 3'd0;
	localparam logic [CfgIdxW-1:0] RegMaxAngle  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegAngleStep = 3'd2;
	localparam logic [CfgIdxW-1:0] RegSpeed     = 3'd3;
	localparam logic [CfgIdxW-1:0] RegStuck     = 3'd4;
	localparam logic [CfgIdxW-1:0] RegCooldown  = 3'd5;

	typedef struct packed {
		logic signed [AngleW-1:0] angle_lo;
		logic signed [AngleW-1:0] angle_hi;
		logic [AngleW-1:0]        angle_step;
		logic [SpeedW-1:0]        speed_mag;
		logic [AgeW-1:0]          stuck_ticks;
		logic [AgeW-1:0]          cooldown_ticks;
	} cfg_t;

	typedef struct packed {
		logic                     moving_forward;
		logic                     sampling_on;
		logic [StepW-1:0]         prev_step;
		logic                     step_seen;
		logic [AgeW-1:0]          idle_age;
		logic [AgeW-1:0]          change_age;
		logic signed [AngleW-1:0] last_sample_angle;
		logic                     have_sample;
		logic [AgeW-1:0]          sweep_count;
	} state_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic                     sample_valid;
		logic signed [AngleW-1:0] sample_angle;
		logic [RangeW-1:0]        sample_range;
		logic                     scan_done;
		logic [AgeW-1:0]          scan_length;
	} result_t;

	function automatic logic [AgeW-1:0] sat_inc(input logic [AgeW-1:0] v);
		sat_inc = (v == AgeMax) ? AgeMax : v + AgeW'(1);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/lsc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lsc_core import lsc_pkg::*; (
	input  cfg_t                     cfg,
	input  state_t                   st,
	input  logic signed [AngleW-1:0] angle,
	input  logic [StepW-1:0]         step_count,
	input  logic [RangeW-1:0]        range,
	output state_t                   st_next,
	output result_t                  res
);

	logic              step_changed;
	logic [AgeW-1:0]   idle_next;
	logic [AgeW-1:0]   change_inc;
	logic              stuck;
	logic              cooled;
	logic [SpeedW-1:0] speed;
	logic              stuck_turn;
	logic              fwd_turn;
	logic              bwd_turn;
	logic              fwd_next;
	logic              sampling_next;
	logic signed [AngleW:0] diff;
	logic [AngleW:0]   abs_diff;
	logic              take;
	logic [AgeW-1:0]   count_base;

	always_comb begin
		step_changed = !st.step_seen || (step_count != st.prev_step);
		idle_next    = step_changed ? '0 : sat_inc(st.idle_age);
		change_inc   = sat_inc(st.change_age);
		stuck        = idle_next > cfg.stuck_ticks;
		cooled       = change_inc > cfg.cooldown_ticks;
		speed        = (cfg.speed_mag > SpeedCap) ? SpeedCap : cfg.speed_mag;
		stuck_turn   = stuck && cooled && (speed != '0);

		fwd_turn = (angle < cfg.angle_lo) || (stuck_turn && !st.moving_forward);
		bwd_turn = !fwd_turn && ((angle > cfg.angle_hi) || (stuck_turn && st.moving_forward));

		fwd_next      = fwd_turn ? 1'b1 : (bwd_turn ? 1'b0 : st.moving_forward);
		sampling_next = fwd_turn ? 1'b1 : (bwd_turn ? 1'b0 : st.sampling_on);

		diff     = {st.last_sample_angle[AngleW-1], st.last_sample_angle}
			- {angle[AngleW-1], angle};
		abs_diff = diff[AngleW] ? (AngleW+1)'(-diff) : (AngleW+1)'(diff);
		take     = sampling_next && (!st.have_sample || (abs_diff > {1'b0, cfg.angle_step}));

		count_base = bwd_turn ? '0 : st.sweep_count;

		st_next.moving_forward    = fwd_next;
		st_next.sampling_on       = sampling_next;
		st_next.prev_step         = step_count;
		st_next.step_seen         = 1'b1;
		st_next.idle_age          = idle_next;
		st_next.change_age        = fwd_turn ? '0 : change_inc;
		st_next.last_sample_angle = take ? angle : st.last_sample_angle;
		st_next.have_sample       = st.have_sample || take;
		st_next.sweep_count       = take ? sat_inc(count_base) : count_base;

		res.drive        = fwd_next ? DriveW'(speed) : DriveW'(0) - DriveW'(speed);
		res.sample_valid = take;
		res.sample_angle = take ? angle : '0;
		res.sample_range = take ? range : '0;
		res.scan_done    = bwd_turn && (st.sweep_count != '0);
		res.scan_length  = (bwd_turn && (st.sweep_count != '0)) ? st.sweep_count : '0;
	end

endmodule

`default_nettype wire

@@ rtl/core/lidar_sweep_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// a transferred poll tick's result is held in the registered result output
// throughput: one tick per cycle unless the output stalls; the state update is
// a single compare-and-count pass; the result register lets a new tick in while
// the current result waits, as long as the output side is not stalling
// reset (arst_n low): config/state registers to defaults, pivot forward, sampling off
module lidar_sweep_controller import lsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_wen,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]      cfg_data,
	// poll tick input
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [AngleW-1:0] angle,
	input  logic [StepW-1:0]         step_count,
	input  logic [RangeW-1:0]        range,
	// result output
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DriveW-1:0] drive,
	output logic                     sample_valid,
	output logic signed [AngleW-1:0] sample_angle,
	output logic [RangeW-1:0]        sample_range,
	output logic                     scan_done,
	output logic [AgeW-1:0]          scan_length
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_next;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    in_xfer;

	// configuration registers, to be written by the user only while the block is idle; the block leaves this unchecked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_lo       <= -16'sd9000;
			cfg_q.angle_hi       <= 16'sd9000;
			cfg_q.angle_step     <= 16'd100;
			cfg_q.speed_mag      <= 7'd100;
			cfg_q.stuck_ticks    <= 16'd5;
			cfg_q.cooldown_ticks <= 16'd25;
		end else if (cfg_wen) begin
			case (cfg_index)
				RegMinAngle:  cfg_q.angle_lo       <= cfg_data;
				RegMaxAngle:  cfg_q.angle_hi       <= cfg_data;
				RegAngleStep: cfg_q.angle_step     <= cfg_data;
				RegSpeed:     cfg_q.speed_mag      <= cfg_data[SpeedW-1:0];
				RegStuck:     cfg_q.stuck_ticks    <= cfg_data;
				RegCooldown:  cfg_q.cooldown_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// a tick is taken whenever the result register is free or being drained
	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	lsc_core u_core (
		.cfg        (cfg_q),
		.st         (st_q),
		.angle      (angle),
		.step_count (step_count),
		.range      (range),
		.st_next    (st_next),
		.res        (res)
	);

	// sweep state advances once per transferred tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.moving_forward    <= 1'b1;
			st_q.sampling_on       <= 1'b0;
			st_q.prev_step         <= '0;
			st_q.step_seen         <= 1'b0;
			st_q.idle_age          <= '0;
			st_q.change_age        <= '0;
			st_q.last_sample_angle <= '0;
			st_q.have_sample       <= 1'b0;
			st_q.sweep_count       <= '0;
		end else if (in_xfer) begin
			st_q <= st_next;
		end
	end

	// result register: valid is control, payload loads with each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign drive        = res_q.drive;
	assign sample_valid = res_q.sample_valid;
	assign sample_angle = res_q.sample_angle;
	assign sample_range = res_q.sample_range;
	assign scan_done    = res_q.scan_done;
	assign scan_length  = res_q.scan_length;

	// a turn backward ends sampling, so a sweep publish never carries a sample
	a_done_no_sample: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(scan_done && sample_valid))
		else $error("scan_done together with sample_valid");

	// scan length only reported with a publish, and never zero then
	a_length_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scan_done == (scan_length != '0)))
		else $error("scan_length does not match scan_done");

	// every transferred tick yields a result in the next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("transferred tick without result");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import lsc_pkg::*;

	localparam int HalfPeriod = 6;
	localparam int QuietLimit = 2000;   // cycles without any transfer before giving up
	localparam int PhaseTicks = 120;
	localparam int PhaseCount = 14;
	localparam int SatTicks   = 50;     // frozen-encoder stretch sampled every tick

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wen;
	logic [CfgIdxW-1:0]       cfg_index;
	logic [CfgDataW-1:0]      cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [AngleW-1:0] angle;
	logic [StepW-1:0]         step_count;
	logic [RangeW-1:0]        range;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DriveW-1:0] drive;
	logic                     sample_valid;
	logic signed [AngleW-1:0] sample_angle;
	logic [RangeW-1:0]        sample_range;
	logic                     scan_done;
	logic [AgeW-1:0]          scan_length;

	// per-side idling mode, flipped now and then so busy and quiet stretches alternate
	bit send_lazy;
	bit recv_lazy;
	bit lazy_ok;

	// mirror of the pivot controller: register copy, sweep state and the
	// queue of poll results still owed by the block
	class sweep_book;
		int               lo_limit, hi_limit, min_move, speed_reg, stuck_limit, cool_limit;
		bit               fwd, sampling, step_seen, have_sample;
		logic [StepW-1:0] prev_step;
		int               idle_age, change_age, last_angle, sweep_count;
		result_t          due_ticks[$];
		int               errors;
		int               checked;

		function new();
			lo_limit    = -9000;
			hi_limit    = 9000;
			min_move    = 100;
			speed_reg   = 100;
			stuck_limit = 5;
			cool_limit  = 25;
			fwd         = 1'b1;
			sampling    = 1'b0;
			step_seen   = 1'b0;
			have_sample = 1'b0;
			prev_step   = '0;
			idle_age    = 0;
			change_age  = 0;
			last_angle  = 0;
			sweep_count = 0;
			errors      = 0;
			checked     = 0;
		endfunction

		function void load_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				RegMinAngle:  lo_limit    = int'($signed(val));
				RegMaxAngle:  hi_limit    = int'($signed(val));
				RegAngleStep: min_move    = int'(val);
				RegSpeed:     speed_reg   = int'(val[SpeedW-1:0]);
				RegStuck:     stuck_limit = int'(val);
				RegCooldown:  cool_limit  = int'(val);
				default: ;
			endcase
		endfunction

		// one poll tick: ages, turn decision, sampling, drive
		function void predict_tick(logic signed [AngleW-1:0] a, logic [StepW-1:0] st,
			logic [RangeW-1:0] rg);
			result_t r;
			int      ai;
			int      spd;
			int      moved;
			bit      stuck;
			bit      cooled;
			ai  = int'(a);
			spd = (speed_reg > 100) ? 100 : speed_reg;
			if (!step_seen || st != prev_step) begin
				idle_age  = 0;
				prev_step = st;
				step_seen = 1'b1;
			end else if (idle_age < 65535) begin
				idle_age++;
			end
			if (change_age < 65535)
				change_age++;
			stuck  = idle_age > stuck_limit;
			cooled = change_age > cool_limit;
			r = '0;
			// forward turn has priority over backward turn
			if (ai < lo_limit || (stuck && cooled && spd != 0 && !fwd)) begin
				fwd        = 1'b1;
				change_age = 0;
				sampling   = 1'b1;
			end else if (ai > hi_limit || (stuck && cooled && spd != 0 && fwd)) begin
				fwd = 1'b0;
				if (sweep_count != 0) begin
					r.scan_done   = 1'b1;
					r.scan_length = AgeW'(sweep_count);
				end
				sweep_count = 0;
				sampling    = 1'b0;
			end
			if (sampling) begin
				moved = last_angle - ai;
				if (moved < 0)
					moved = -moved;
				if (!have_sample || moved > min_move) begin
					r.sample_valid = 1'b1;
					r.sample_angle = a;
					r.sample_range = rg;
					have_sample    = 1'b1;
					last_angle     = ai;
					if (sweep_count < 65535)
						sweep_count++;
				end
			end
			r.drive = DriveW'(fwd ? spd : -spd);
			due_ticks = {due_ticks, r};
		endfunction

		task report(string what);
			// keep the log readable when everything goes wrong
			if (errors < 100)
				$display("mismatch at result %0d: %s", checked, what);
			errors++;
		endtask

		task match_tick(result_t got);
			result_t want;
			if (due_ticks.size() == 0) begin
				report($sformatf("result with nothing pending, drive %0d", got.drive));
				return;
			end
			want = due_ticks.pop_front();
			if (got.drive !== want.drive)
				report($sformatf("drive %0d, want %0d", got.drive, want.drive));
			if (got.sample_valid !== want.sample_valid)
				report($sformatf("sample_valid %b, want %b", got.sample_valid,
					want.sample_valid));
			if (got.sample_angle !== want.sample_angle)
				report($sformatf("sample_angle %0d, want %0d", got.sample_angle,
					want.sample_angle));
			if (got.sample_range !== want.sample_range)
				report($sformatf("sample_range %0d, want %0d", got.sample_range,
					want.sample_range));
			if (got.scan_done !== want.scan_done)
				report($sformatf("scan_done %b, want %b", got.scan_done, want.scan_done));
			if (got.scan_length !== want.scan_length)
				report($sformatf("scan_length %0d, want %0d", got.scan_length,
					want.scan_length));
			checked++;
		endtask
	endclass

	sweep_book book = new();

	lidar_sweep_controller uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.angle        (angle),
		.step_count   (step_count),
		.range        (range),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive        (drive),
		.sample_valid (sample_valid),
		.sample_angle (sample_angle),
		.sample_range (sample_range),
		.scan_done    (scan_done),
		.scan_length  (scan_length)
	);

	initial begin
		clk = 1'b0;
		forever #(HalfPeriod) clk = ~clk;
	end

	// one poll tick transfer; valid stays high afterwards and is dropped between
	// transfers when a random idle gap is inserted or when the sender drains
	task automatic send_tick(input logic signed [AngleW-1:0] a, input logic [StepW-1:0] st,
		input logic [RangeW-1:0] rg);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_lazy = !send_lazy;
		gap = (send_lazy && lazy_ok) ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		angle      <= a;
		step_count <= st;
		range      <= rg;
		do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
		book.predict_tick(a, st, rg);
	endtask

	// sender holds off until every owed result has been transferred
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.due_ticks.size() != 0)
			@(posedge clk);
		// let the result register settle
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		book.load_reg(idx, val);
	endtask

	// full register load, only with the block idle
	task automatic set_config(input int mn, input int mx, input int stp, input int spd,
		input int stk, input int cool);
		drain();
		write_reg(RegMinAngle, CfgDataW'(mn));
		write_reg(RegMaxAngle, CfgDataW'(mx));
		write_reg(RegAngleStep, CfgDataW'(stp));
		write_reg(RegSpeed, CfgDataW'(spd));
		write_reg(RegStuck, CfgDataW'(stk));
		write_reg(RegCooldown, CfgDataW'(cool));
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// simulated pivot: angle follows the predicted drive direction, the encoder
	// advances while moving and freezes during stuck episodes; a few ticks are
	// pure noise
	task automatic run_sweeps(input int n);
		int               pos;
		int               vel;
		int               hold;
		int               roll;
		int               span;
		logic [StepW-1:0] st;
		span = book.hi_limit - book.lo_limit;
		if (span < 0)
			span = -span;
		vel  = span / 25 + 1;
		pos  = (book.lo_limit + book.hi_limit) / 2;
		hold = 0;
		st   = $urandom;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				send_tick(AngleW'($urandom), $urandom, RangeW'($urandom));
			end else begin
				if (hold == 0 && roll < 14)
					hold = $urandom_range(1, (book.stuck_limit < 32) ?
						book.stuck_limit + 8 : 40);
				if (hold > 0) begin
					hold--;
				end else begin
					st = (roll < 16) ? $urandom : st + StepW'($urandom_range(1, 40));
					if (book.speed_reg != 0)
						pos += (book.fwd ? 1 : -1) * $urandom_range(0, vel);
					if (pos > 32767)
						pos = 32767;
					if (pos < -32768)
						pos = -32768;
				end
				send_tick(AngleW'(pos), st, RangeW'($urandom));
			end
		end
	endtask

	// result side: random stalls in lazy stretches, compare on transfer
	initial begin : result_side
		int      pause;
		result_t got;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_lazy = !recv_lazy;
			pause = (recv_lazy && lazy_ok) ? $urandom_range(0, 7) : 0;
			if (pause > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (pause - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.drive        = drive;
			got.sample_valid = sample_valid;
			got.sample_angle = sample_angle;
			got.sample_range = sample_range;
			got.scan_done    = scan_done;
			got.scan_length  = scan_length;
			book.match_tick(got);
		end
	end

	// watchdog: a long stretch with no transfer on either side means a hang
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int mn, mx, stp, spd, stk, cool, tmp, roll;
		arst_n     = 1'b0;
		cfg_wen    = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		angle      = '0;
		step_count = '0;
		range      = '0;
		out_stall  = 1'b0;
		send_lazy  = 1'b1;
		recv_lazy  = 1'b1;
		lazy_ok    = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: first tick clears idle age even though the count matches
		send_tick(0, 0, 0);
		// far below the lower limit: forward turn, first sample taken whatever the angle
		send_tick(-32768, 1, 16'hffff);
		// inside the sample increment: no sample
		send_tick(-32700, 2, 1234);
		send_tick(0, 32'h7fff_ffff, 16'hffff);
		// far above the upper limit: backward turn publishes the sweep
		send_tick(32767, 32'h8000_0000, 0);
		// second turn with an empty sweep publishes nothing
		send_tick(32767, 32'h8000_0000, 7);

		// speed above the cap, zero stuck and cooldown: encoder freeze flips direction
		set_config(-9000, 9000, 0, 127, 0, 0);
		send_tick(100, 5, 11);
		send_tick(100, 5, 12);
		send_tick(100, 5, 13);
		send_tick(-50, 5, 14);

		// limits out of order and zero speed: only limit turns act, forward wins
		set_config(18000, -18000, 50, 0, 0, 0);
		send_tick(0, 9, 1);
		send_tick(0, 9, 2);
		send_tick(18001, 9, 3);

		// widest limits, largest increment, counters that never expire
		set_config(-18000, 18000, 36000, 1, 65535, 65535);
		send_tick(-18001, 10, 4);
		send_tick(-18000, 10, 5);
		send_tick(18000, 10, 6);
		send_tick(18001, 11, 7);

		// frozen encoder with counters that never expire, alternating angle sampled
		// every tick, back to back on both sides
		set_config(-18000, 18000, 0, 100, 65535, 65535);
		lazy_ok = 1'b0;
		send_tick(-18001, 77, 1);
		for (int i = 0; i < SatTicks; i++)
			send_tick(AngleW'(i % 2), 77, RangeW'(i));
		send_tick(18001, 77, 2);
		lazy_ok = 1'b1;

		// random phases, the first two at the register extremes
		for (int p = 0; p < PhaseCount; p++) begin
			if (p == 0) begin
				mn = -18000; mx = 18000; stp = 36000; spd = 1; stk = 0; cool = 0;
			end else if (p == 1) begin
				mn = -18000; mx = 18000; stp = 0; spd = 100; stk = 65535; cool = 65535;
			end else begin
				mn = $urandom_range(0, 36000) - 18000;
				mx = $urandom_range(0, 36000) - 18000;
				// mostly ordered limits, sometimes crossed
				if (p % 5 != 2 && mn > mx) begin
					tmp = mn;
					mn  = mx;
					mx  = tmp;
				end
				tmp  = (mx > mn) ? (mx - mn) : (mn - mx);
				stp  = $urandom_range(0, tmp / 12 + 1);
				roll = $urandom_range(0, 9);
				spd  = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(101, 127) :
					$urandom_range(1, 100);
				stk  = $urandom_range(0, 12);
				cool = $urandom_range(0, 40);
			end
			set_config(mn, mx, stp, spd, stk, cool);
			run_sweeps(PhaseTicks);
		end

		drain();
		repeat (4) @(posedge clk);
		if (book.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/lsc_pkg.sv
rtl/core/lsc_core.sv
rtl/core/lidar_sweep_controller.sv
test/tb_top.sv
